// ===== hdl/assembly_token_lexer_core_macros.svh =====
// assertion macros for the assembly token lexer
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSEMBLY_TOKEN_LEXER_CORE_MACROS_SVH
`define ASSEMBLY_TOKEN_LEXER_CORE_MACROS_SVH

// same-cycle implication
`define ATL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lexer check failed");

// next-cycle implication
`define ATL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lexer check failed");

`endif

// ===== hdl/atl_pkg.sv =====
// shared types and constants of the assembly token lexer
// no dependencies
`default_nettype none

package atl_pkg;

  localparam logic [7:0] CharHash   = 8'h23;
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharPct    = 8'h25;
  localparam logic [7:0] CharColon  = 8'h3a;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharFour   = 8'h34;
  localparam logic [7:0] CharUpperR = 8'h52;
  localparam logic [7:0] CaseOffset = 8'd32;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_HEX = 2'd1,
    BASE_BIN = 2'd2,
    BASE_ALT = 2'd3
  } base_e;

  typedef enum logic [1:0] {
    KIND_WORD   = 2'd0,
    KIND_NUMBER = 2'd1,
    KIND_REG    = 2'd2,
    KIND_RSVD   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_DIGIT = 2'd1,
    ERR_EMPTY = 2'd2,
    ERR_RSVD  = 2'd3
  } err_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } in_req_t;

  typedef struct packed {
    logic [7:0] upper_char;
    logic       char_in_word;
    logic       word_end;
    logic [1:0] token_kind;
    logic [7:0] number_value;
    logic [2:0] register_index;
    logic [1:0] error_code;
  } out_req_t;

  typedef struct packed {
    logic [7:0] upper;
    logic       is_word;
    logic       is_digit;
    logic [3:0] digit;
  } char_info_t;

endpackage

`default_nettype wire

// ===== hdl/atl_char_class.sv =====
// character classifier: upper-casing, word characters and digit values
// depends on atl_pkg
`default_nettype none

module atl_char_class (
  input  wire logic [7:0]         char_i,
  output atl_pkg::char_info_t     info_o
);
  import atl_pkg::*;

  logic [7:0] upper;

  always_comb begin
    upper = char_i;
    if (char_i inside {[8'h61:8'h7a]}) begin
      upper = char_i - CaseOffset;
    end
  end

  always_comb begin
    info_o.upper    = upper;
    info_o.is_word  = (char_i inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]}) ||
                      (char_i == CharColon) || (char_i == CharHash) ||
                      (char_i == CharDollar) || (char_i == CharPct);
    info_o.is_digit = 1'b0;
    info_o.digit    = 4'd0;
    if (upper inside {[8'h30:8'h39]}) begin
      info_o.is_digit = 1'b1;
      info_o.digit    = upper[3:0];
    end else if (upper inside {[8'h41:8'h46]}) begin
      info_o.is_digit = 1'b1;
      info_o.digit    = upper[3:0] + 4'd9;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/atl_word_state.sv =====
// running word state, literal accumulation and token classing
// depends on atl_pkg
`default_nettype none

module atl_word_state (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic                eot_i,
  input  wire atl_pkg::char_info_t info_i,
  output atl_pkg::out_req_t        res_o
);
  import atl_pkg::*;

  logic       in_word_q, in_word_d;
  logic [1:0] pos_q, pos_d;
  logic [7:0] first_q, first_d;
  logic [7:0] second_q, second_d;
  base_e      base_q, base_d;
  logic [7:0] acc_q, acc_d;
  logic       err_q, err_d;

  logic       digit_ok;
  logic [7:0] acc_scaled;
  logic       take_digit;
  logic       open_word;
  logic       close_word;
  logic       has_digits;

  always_comb begin
    case (base_q)
      BASE_HEX: begin
        digit_ok   = info_i.is_digit;
        acc_scaled = {acc_q[3:0], 4'd0};
      end
      BASE_BIN: begin
        digit_ok   = info_i.is_digit && (info_i.digit <= 4'd1);
        acc_scaled = {acc_q[6:0], 1'b0};
      end
      default: begin
        digit_ok   = info_i.is_digit && (info_i.digit <= 4'd9);
        acc_scaled = {acc_q[4:0], 3'd0} + {acc_q[6:0], 1'b0};
      end
    endcase
  end

  always_comb begin
    in_word_d  = in_word_q;
    pos_d      = pos_q;
    first_d    = first_q;
    second_d   = second_q;
    base_d     = base_q;
    acc_d      = acc_q;
    err_d      = err_q;
    take_digit = 1'b0;
    if (info_i.is_word) begin
      if (!in_word_q) begin
        in_word_d = 1'b1;
        pos_d     = 2'd1;
        first_d   = info_i.upper;
        second_d  = 8'd0;
        base_d    = BASE_DEC;
        acc_d     = 8'd0;
        err_d     = 1'b0;
      end else begin
        if (pos_q == 2'd1) begin
          second_d = info_i.upper;
          if (first_q == CharHash) begin
            if (info_i.upper == CharDollar) begin
              base_d = BASE_HEX;
            end else if (info_i.upper == CharPct) begin
              base_d = BASE_BIN;
            end else begin
              take_digit = 1'b1;
            end
          end
        end else if (first_q == CharHash) begin
          take_digit = 1'b1;
        end
        if (pos_q != 2'd3) begin
          pos_d = pos_q + 2'd1;
        end
      end
    end
    if (take_digit) begin
      if (digit_ok) begin
        acc_d = acc_scaled + {4'd0, info_i.digit};
      end else begin
        err_d = 1'b1;
      end
    end
    open_word  = in_word_d;
    close_word = open_word && (!info_i.is_word || eot_i);
    if (close_word) begin
      in_word_d = 1'b0;
    end
  end

  always_comb begin
    has_digits = ((base_d == BASE_HEX) || (base_d == BASE_BIN)) ? (pos_d == 2'd3)
                                                                : (pos_d >= 2'd2);
    res_o                = '0;
    res_o.upper_char     = info_i.upper;
    res_o.char_in_word   = info_i.is_word;
    res_o.word_end       = close_word;
    if (close_word) begin
      if (first_d == CharHash) begin
        res_o.token_kind = KIND_NUMBER;
        if (err_d) begin
          res_o.error_code   = ERR_DIGIT;
          res_o.number_value = acc_d;
        end else if (!has_digits) begin
          res_o.error_code   = ERR_EMPTY;
        end else begin
          res_o.number_value = acc_d;
        end
      end else if ((first_d == CharUpperR) && (pos_d == 2'd2) &&
                   (second_d >= CharZero) && (second_d <= CharFour)) begin
        res_o.token_kind     = KIND_REG;
        res_o.register_index = second_d[2:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_word_q <= 1'b0;
      pos_q     <= 2'd0;
      first_q   <= 8'd0;
      second_q  <= 8'd0;
      base_q    <= BASE_DEC;
      acc_q     <= 8'd0;
      err_q     <= 1'b0;
    end else if (step_i) begin
      in_word_q <= in_word_d;
      pos_q     <= pos_d;
      first_q   <= first_d;
      second_q  <= second_d;
      base_q    <= base_d;
      acc_q     <= acc_d;
      err_q     <= err_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/assembly_token_lexer_core.sv =====
// top level of the assembly token lexer: input register, lexer logic, result register
// depends on atl_pkg, atl_char_class, atl_word_state and the assertion macro header
`default_nettype none

// Takes one source character per request and returns one result request per
// character. Throughput is one request per clock while the output is not held
// back: a character is captured in the input register at the accepting edge,
// classed and folded into the running word state, and its result is registered
// in the output register, raising out_valid_o, once that register is free or being read out.
// The input side keeps accepting while a result waits, as long as the output
// register frees up in that cycle.
module assembly_token_lexer_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire atl_pkg::in_req_t    in_req_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output atl_pkg::out_req_t        out_req_o
);
  import atl_pkg::*;

`include "assembly_token_lexer_core_macros.svh"

  in_req_t    in_q;
  logic       in_valid_q;
  out_req_t   res_q;
  logic       res_valid_q;
  logic       advance;
  char_info_t info;
  out_req_t   res;

  assign advance    = in_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  atl_char_class u_class (
    .char_i (in_q.char_in),
    .info_o (info)
  );

  atl_word_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .eot_i  (in_q.end_of_text),
    .info_i (info),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_req_o   = res_q;

  `ATL_ASSERT_NEXT(a_accept_lands, in_valid_i && in_ready_o, in_valid_q)
  `ATL_ASSERT_NOW(a_no_word_no_kind, out_valid_o && !out_req_o.word_end, out_req_o.token_kind == KIND_WORD && out_req_o.error_code == ERR_NONE)
  `ATL_ASSERT_NOW(a_value_only_number, out_valid_o && out_req_o.token_kind != KIND_NUMBER, out_req_o.number_value == 8'd0 && out_req_o.error_code == ERR_NONE)
  `ATL_ASSERT_NOW(a_reg_in_range, out_valid_o && out_req_o.token_kind == KIND_REG, out_req_o.register_index <= 3'd4)

endmodule

`default_nettype wire

// ===== bench/assembly_token_lexer_core_checker.sv =====
// checker for the assembly token lexer: predicts each result from the accepted characters
// and compares it with what the block hands out; depends on atl_pkg
module assembly_token_lexer_core_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  atl_pkg::in_req_t  in_req_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  atl_pkg::out_req_t out_req_i,
  output int                mismatch_count_o,
  output int                pending_o,
  output int                numbers_o,
  output int                registers_o,
  output int                plain_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import atl_pkg::*;

  localparam logic [7:0] ChNine  = "9";
  localparam logic [7:0] ChUpA   = "A";
  localparam logic [7:0] ChUpF   = "F";
  localparam logic [7:0] ChUpZ   = "Z";
  localparam logic [7:0] ChLowA  = "a";
  localparam logic [7:0] ChLowZ  = "z";

  out_req_t   lexed_results[$];
  logic       open_word;
  logic [1:0] word_len;
  logic [7:0] lead_char;
  logic [7:0] next_char;
  base_e      radix;
  logic [7:0] literal_acc;
  logic       bad_digit;

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= ChLowA && c <= ChLowZ) ? c - CaseOffset : c;
  endfunction

  function automatic logic word_char(logic [7:0] c);
    return (c >= CharZero && c <= ChNine) || (c >= ChLowA && c <= ChLowZ) ||
           (c >= ChUpA && c <= ChUpZ) || c == CharColon || c == CharHash ||
           c == CharDollar || c == CharPct;
  endfunction

  task automatic add_digit(input logic [7:0] c);
    int   d;
    int   mul;
    logic bad;
    bad = 1'b0;
    mul = 10;
    d   = 0;
    if (c >= CharZero && c <= ChNine) begin
      d = c - CharZero;
    end else if (c >= ChUpA && c <= ChUpF) begin
      d = c - ChUpA + 10;
    end else begin
      bad = 1'b1;
    end
    if (!bad) begin
      case (radix)
        BASE_HEX: mul = 16;
        BASE_BIN: begin
          mul = 2;
          bad = d > 1;
        end
        default: bad = d > 9;
      endcase
    end
    if (bad) bad_digit = 1'b1;
    else literal_acc = 8'(int'(literal_acc) * mul + d);
  endtask

  task automatic take_char(input logic [7:0] c);
    if (!open_word) begin
      open_word   = 1'b1;
      lead_char   = c;
      next_char   = '0;
      radix       = BASE_DEC;
      literal_acc = '0;
      bad_digit   = 1'b0;
      word_len    = 2'd1;
    end else begin
      if (word_len == 2'd1) begin
        next_char = c;
        if (lead_char == CharHash) begin
          if (c == CharDollar) radix = BASE_HEX;
          else if (c == CharPct) radix = BASE_BIN;
          else add_digit(c);
        end
      end else if (lead_char == CharHash) begin
        add_digit(c);
      end
      if (word_len < 2'd3) word_len++;
    end
  endtask

  task automatic lex_char(input in_req_t rq, output out_req_t res);
    logic [7:0] uc;
    logic       wc;
    logic       prefixed;
    logic       has_digits;
    uc  = fold_case(rq.char_in);
    wc  = word_char(rq.char_in);
    res = '0;
    res.upper_char   = uc;
    res.char_in_word = wc;
    if (wc) take_char(uc);
    if (open_word && (!wc || rq.end_of_text)) begin
      res.word_end = 1'b1;
      if (lead_char == CharHash) begin
        prefixed   = radix == BASE_HEX || radix == BASE_BIN;
        has_digits = prefixed ? word_len >= 2'd3 : word_len >= 2'd2;
        res.token_kind = KIND_NUMBER;
        if (bad_digit) begin
          res.error_code   = ERR_DIGIT;
          res.number_value = literal_acc;
        end else if (!has_digits) begin
          res.error_code = ERR_EMPTY;
        end else begin
          res.number_value = literal_acc;
        end
      end else if (lead_char == CharUpperR && word_len == 2'd2 &&
                   next_char >= CharZero && next_char <= CharFour) begin
        res.token_kind     = KIND_REG;
        res.register_index = 3'(next_char - CharZero);
      end
      open_word = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin
    out_req_t want;
    if (!rst_ni) begin
      lexed_results.delete();
      open_word        = 1'b0;
      word_len         = '0;
      lead_char        = '0;
      next_char        = '0;
      radix            = BASE_DEC;
      literal_acc      = '0;
      bad_digit        = 1'b0;
      mismatch_count_o = 0;
      numbers_o        = 0;
      registers_o      = 0;
      plain_o          = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (lexed_results.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("%t unexpected result %p", $realtime, out_req_i);
        end else begin
          want = lexed_results.pop_front();
          if (out_req_i !== want) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("%t mismatch on char %02h", $realtime, want.upper_char);
              $display("  exp up=%02h w=%0d end=%0d kind=%0d val=%02h reg=%0d err=%0d",
                       want.upper_char, want.char_in_word, want.word_end, want.token_kind,
                       want.number_value, want.register_index, want.error_code);
              $display("  got up=%02h w=%0d end=%0d kind=%0d val=%02h reg=%0d err=%0d",
                       out_req_i.upper_char, out_req_i.char_in_word, out_req_i.word_end,
                       out_req_i.token_kind, out_req_i.number_value,
                       out_req_i.register_index, out_req_i.error_code);
            end
          end
          if (want.word_end) begin
            if (want.token_kind == KIND_NUMBER) numbers_o++;
            else if (want.token_kind == KIND_REG) registers_o++;
            else plain_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        lex_char(in_req_i, want);
        lexed_results.push_back(want);
      end
    end
    pending_o = lexed_results.size();
  end

endmodule

// ===== bench/assembly_token_lexer_core_tb.sv =====
// testbench top for the assembly token lexer: clock, reset, source text and verdict
// depends on atl_pkg, assembly_token_lexer_core and assembly_token_lexer_core_checker
module assembly_token_lexer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import atl_pkg::*;

  localparam int TextLen = 1800;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_ready;
  out_req_t out_req;
  int       errs;
  int       pending;
  int       numbers;
  int       registers;
  int       plain;
  in_req_t  source_text[$];

  always #5 clk_i = ~clk_i;

  assembly_token_lexer_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_req_o  (out_req)
  );

  assembly_token_lexer_core_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_req_i        (in_req),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_req_i       (out_req),
    .mismatch_count_o(errs),
    .pending_o       (pending),
    .numbers_o       (numbers),
    .registers_o     (registers),
    .plain_o         (plain)
  );

  task automatic push_char(input logic [7:0] c, input logic eot);
    in_req_t rq;
    rq.char_in     = c;
    rq.end_of_text = eot;
    source_text.push_back(rq);
  endtask

  task automatic add_text(input string s, input logic eot_last);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i], eot_last && i == s.len() - 1);
  endtask

  function automatic logic [7:0] digit_char(int v, logic lower);
    if (v < 10) return 8'(CharZero + v);
    return 8'((lower ? "a" : "A") + v - 10);
  endfunction

  task automatic build_random_text();
    string wchars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789:#$%";
    string seps   = " ,;\t\n()+-";
    int    pick;
    int    n;
    int    prefix;
    int    radix_max;
    while (source_text.size() < TextLen) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        push_char(CharHash, 1'b0);
        prefix = $urandom_range(0, 2);
        radix_max = prefix == 1 ? 15 : prefix == 2 ? 1 : 9;
        if (prefix == 1) push_char(CharDollar, 1'b0);
        if (prefix == 2) push_char(CharPct, 1'b0);
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 14) == 0)
            push_char(wchars[$urandom_range(0, wchars.len() - 1)], 1'b0);
          else
            push_char(digit_char($urandom_range(0, radix_max), $urandom_range(0, 1)), 1'b0);
        end
      end else if (pick < 55) begin
        push_char($urandom_range(0, 1) ? CharUpperR : "r", 1'b0);
        if ($urandom_range(0, 4) != 0) push_char(8'(CharZero + $urandom_range(0, 4)), 1'b0);
        else push_char(wchars[$urandom_range(0, wchars.len() - 1)], 1'b0);
        if ($urandom_range(0, 5) == 0)
          push_char(wchars[$urandom_range(0, wchars.len() - 1)], 1'b0);
      end else if (pick < 85) begin
        n = $urandom_range(1, 6);
        push_char(wchars[$urandom_range(0, 51)], 1'b0);
        for (int i = 1; i < n; i++)
          push_char(wchars[$urandom_range(0, wchars.len() - 1)], 1'b0);
      end else begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) push_char(8'($urandom_range(0, 255)), 1'b0);
      end
      if ($urandom_range(0, 15) == 0) source_text[$].end_of_text = 1'b1;
      if ($urandom_range(0, 9) != 0) begin
        if ($urandom_range(0, 4) == 0) push_char(8'($urandom_range(0, 255)), 1'b0);
        else push_char(seps[$urandom_range(0, seps.len() - 1)], 1'b0);
        if ($urandom_range(0, 19) == 0) source_text[$].end_of_text = 1'b1;
      end
    end
  endtask

  // receiver: random stalls, one long hold-off to back the block up, then a clean stretch
  initial begin
    int cyc;
    cyc = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc >= 700 && cyc < 900) out_ready <= 1'b0;
      else if (cyc >= 1400 && cyc < 1800) out_ready <= 1'b1;
      else out_ready <= $urandom_range(0, 99) >= 10;
    end
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_req   = '0;
    add_text("#$fF ", 1'b0);
    add_text("#%12,", 1'b0);
    add_text("r4\n", 1'b0);
    add_text("# ", 1'b0);
    add_text("#$", 1'b1);
    add_text("#300", 1'b1);
    push_char(8'hff, 1'b0);
    push_char(8'h00, 1'b0);
    add_text("R5 ", 1'b0);
    build_random_text();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (source_text[idx]) begin
      @(negedge clk_i);
      while (!(idx >= 1200 && idx < 1500) && $urandom_range(0, 99) < 10) begin
        in_valid <= 1'b0;
        @(negedge clk_i);
      end
      in_valid <= 1'b1;
      in_req   <= source_text[idx];
      @(posedge clk_i);
      while (!in_ready) @(posedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("%0d characters lexed with random stalls on both sides", source_text.size());
    $display("%0d number literals, %0d registers, %0d plain words closed",
             numbers, registers, plain);
    if (errs == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/atl_pkg.sv
hdl/atl_char_class.sv
hdl/atl_word_state.sv
hdl/assembly_token_lexer_core.sv
bench/assembly_token_lexer_core_checker.sv
bench/assembly_token_lexer_core_tb.sv
